@@ hdl/rlm_pkg.sv @@
// shared types, constants and codes for the rms level meter
package rlm_pkg;

    // default longest measurement block, in samples
    localparam int MAX_BLOCK_DEF = 1024;

    // widths of the energy accumulator and of the log2 result
    localparam int LOG_W     = 41;
    localparam int EXP_W     = 6;
    localparam int FRAC_BITS = 16;
    localparam int LOG_QW    = EXP_W + FRAC_BITS;
    localparam int NORM_STEPS = 6;
    localparam int STEP_W    = 4;
    localparam int MANT_W    = 32;
    localparam int D_W       = 24;
    localparam int PROD_W    = 43;
    localparam int CNT_OUT_W = 11;

    // 2*log2(32767) in q.16 and 10*log10(2) in q.16
    localparam logic [D_W-1:0]    LOG2_FS2 = 24'd1966074;
    localparam logic signed [18:0] DB_K    = 19'sd197283;

    localparam logic signed [15:0] LEVEL_MIN = 16'sh8000;
    localparam logic signed [15:0] LEVEL_MAX = 16'sd256;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [15:0]     level_db;
        logic                   silent;
        logic [CNT_OUT_W-1:0]   block_count;
    } t_out;

    typedef enum logic [3:0] {
        S_ACCUM,
        S_LOAD,
        S_NORM,
        S_MANT,
        S_FRAC,
        S_STORE,
        S_DIFF,
        S_MULT,
        S_OUT
    } t_state;

    typedef enum logic {
        OP_ENERGY,
        OP_COUNT
    } t_op_sel;

    typedef struct packed {
        logic              acc_en;
        logic              norm_load;
        logic              norm_step;
        logic [STEP_W-1:0] step;
        logic              mant_load;
        logic              frac_step;
        t_op_sel           sel;
        logic              store_log;
        logic              diff_en;
        logic              mult_en;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic blk_end;
        logic out_free;
    } t_dp_status;

endpackage

@@ hdl/rlm_ctrl.sv @@
// sequencer for accumulation, the two log2 evaluations and the dB scaling
module rlm_ctrl
    import rlm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_op_sel           r_sel, n_sel;

    logic norm_last;
    logic frac_last;

    assign norm_last = (r_step == STEP_W'(NORM_STEPS - 1));
    assign frac_last = (r_step == STEP_W'(FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_step  <= '0;
            r_sel   <= OP_ENERGY;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sel   <= n_sel;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = '0;
        n_sel   = r_sel;
        unique case (r_state)
            S_ACCUM: begin
                n_sel = OP_ENERGY;
                if (i_in_valid && i_status.blk_end) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_NORM;
            end
            S_NORM: begin
                if (norm_last) begin
                    n_state = S_MANT;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_MANT: begin
                n_state = S_FRAC;
            end
            S_FRAC: begin
                if (frac_last) begin
                    n_state = S_STORE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_STORE: begin
                if (r_sel == OP_ENERGY) begin
                    n_sel   = OP_COUNT;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_state = S_MULT;
            end
            S_MULT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_cmd.step = r_step;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_ACCUM: begin
                o_in_ready   = 1'b1;
                o_cmd.acc_en = i_in_valid;
            end
            S_LOAD:  o_cmd.norm_load = 1'b1;
            S_NORM:  o_cmd.norm_step = 1'b1;
            S_MANT:  o_cmd.mant_load = 1'b1;
            S_FRAC:  o_cmd.frac_step = 1'b1;
            S_STORE: o_cmd.store_log = 1'b1;
            S_DIFF:  o_cmd.diff_en   = 1'b1;
            S_MULT:  o_cmd.mult_en   = 1'b1;
            S_OUT:   o_cmd.out_load  = i_status.out_free;
            default: o_cmd.acc_en    = 1'b0;
        endcase
    end

    a_end_starts_energy_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.acc_en && i_status.blk_end) |=> (r_state == S_LOAD) && (r_sel == OP_ENERGY))
        else $error("block end did not start the energy log2");

    a_norm_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_step < STEP_W'(NORM_STEPS)))
        else $error("normalise step out of range");

    a_count_log_then_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE && r_sel == OP_COUNT) |=> (r_state == S_DIFF))
        else $error("count log2 not followed by difference");

endmodule

@@ hdl/rlm_dp.sv @@
// datapath: energy accumulator, shared log2 unit, dB scaling, output register
module rlm_dp
    import rlm_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in        i_in_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);

    localparam int CW = $clog2(MAX_BLOCK + 1);

    // accumulation
    logic [LOG_W-1:0] r_acc_e;
    logic [CW-1:0]    r_acc_c;
    logic [15:0]      mag;
    logic [31:0]      sq;
    logic [LOG_W:0]   sum;
    logic [LOG_W-1:0] e_nx;
    logic [CW-1:0]    c_nx;

    // block snapshot
    logic [LOG_W-1:0] r_snap_e;
    logic [CW-1:0]    r_snap_c;

    // log2 unit
    logic [LOG_W-1:0]  r_nx;
    logic [EXP_W-1:0]  r_np;
    logic [MANT_W-1:0] r_m;
    logic [FRAC_BITS-1:0] r_frac;
    logic [5:0]        sh;
    logic [LOG_W-1:0]  top;
    logic [2*MANT_W-1:0] msq;
    logic [MANT_W:0]   t;
    logic [LOG_QW-1:0] r_log_e;
    logic [LOG_QW-1:0] r_log_c;

    // scaling
    logic signed [D_W-1:0]    r_d;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [15:0]       lvl;

    logic r_out_valid;
    t_out r_out;

    assign mag  = i_in_data.sample[15] ? (~i_in_data.sample + 16'd1) : i_in_data.sample;
    assign sq   = mag * mag;
    assign sum  = {1'b0, r_acc_e} + (LOG_W + 1)'(sq);
    assign e_nx = sum[LOG_W] ? {LOG_W{1'b1}} : sum[LOG_W-1:0];
    assign c_nx = r_acc_c + CW'(1);

    assign o_status.blk_end  = i_in_data.last || (c_nx == CW'(MAX_BLOCK));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_e <= '0;
            r_acc_c <= '0;
        end else if (i_cmd.acc_en) begin
            if (o_status.blk_end) begin
                r_acc_e <= '0;
                r_acc_c <= '0;
            end else begin
                r_acc_e <= e_nx;
                r_acc_c <= c_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en && o_status.blk_end) begin
            r_snap_e <= e_nx;
            r_snap_c <= c_nx;
        end
    end

    // binary-search normalise: shifts of 32, 16, 8, 4, 2, 1
    assign sh  = 6'(6'd32 >> i_cmd.step[2:0]);
    assign top = r_nx >> (6'(LOG_W) - sh);

    // one fraction bit per squaring
    assign msq = r_m * r_m;
    assign t   = msq[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_load) begin
            r_nx <= (i_cmd.sel == OP_ENERGY) ? r_snap_e : LOG_W'(r_snap_c);
            r_np <= EXP_W'(LOG_W - 1);
        end else if (i_cmd.norm_step && (top == '0)) begin
            r_nx <= r_nx << sh;
            r_np <= r_np - sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mant_load) begin
            r_m    <= r_nx[LOG_W-1 -: MANT_W];
            r_frac <= '0;
        end else if (i_cmd.frac_step) begin
            if (t[MANT_W]) begin
                r_m    <= t[MANT_W:1];
                r_frac <= {r_frac[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_m    <= t[MANT_W-1:0];
                r_frac <= {r_frac[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_log) begin
            if (i_cmd.sel == OP_ENERGY) begin
                r_log_e <= {r_np, r_frac};
            end else begin
                r_log_c <= {r_np, r_frac};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_d <= D_W'(r_log_e) - D_W'(r_log_c) - LOG2_FS2;
        end
        if (i_cmd.mult_en) begin
            r_prod <= r_d * DB_K;
        end
    end

    // round half up, then clamp
    assign rnd = (r_prod + (PROD_W'(1) <<< 23)) >>> 24;

    always_comb begin
        priority if (rnd > PROD_W'(LEVEL_MAX)) begin
            lvl = LEVEL_MAX;
        end else if (rnd < PROD_W'(LEVEL_MIN)) begin
            lvl = LEVEL_MIN;
        end else begin
            lvl = 16'(rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.silent      <= (r_snap_e == '0);
            r_out.level_db    <= (r_snap_e == '0) ? LEVEL_MIN : lvl;
            r_out.block_count <= CNT_OUT_W'(r_snap_c);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_c < CW'(MAX_BLOCK))
        else $error("sample count reached the block limit without ending");

    a_normalised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mant_load && (r_nx != '0)) |-> r_nx[LOG_W-1])
        else $error("log2 operand not normalised");

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

@@ hdl/rms_level_meter_db_core.sv @@
// top level of the rms level meter in dBFS
// Takes signed 16-bit samples, one request per clock while a block is being
// gathered, and sums their squares (saturating at 41 bits). A block closes on
// the sample flagged last, or on the MAX_BLOCK-th sample. It then reports
// 10*log10(energy/count) relative to full scale 32767 as signed q7.8 dB,
// clamped to [-128, +1] dB, with a silent flag for an all-zero block and the
// sample count. After the closing sample the input stalls while the single
// log2 unit (one 32x32 squaring per fraction bit) runs twice, each pass
// 6 normalise steps plus 16 fraction bits plus the load, mantissa load and
// store, followed by the difference, the dB multiply and the output load.
// Samples are taken again once the result sits in the output register.
module rms_level_meter_db_core
    import rlm_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)(
    input  logic i_clk,
    input  logic i_rst_n,
    // sample requests
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    // result requests
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // command and status between sequencer and datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer: accumulate, log2 of energy, log2 of count, scale, present
    rlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath, including the output register that decouples the result side
    rlm_dp #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/rms_level_meter_db_core_test.sv @@
// self-checking testbench for the rms level meter in dBFS
module rms_level_meter_db_core_test;
    import rlm_pkg::*;

    // share of cycles in which either side idles, in percent
    localparam int IDLE_PCT       = 27;
    // receiver hold-off, long enough for two finished blocks to pile up
    localparam int HOLD_CYCLES    = 400;
    // quiet cycles allowed: the hold-off, two log passes and idling, several times over
    localparam int WATCHDOG_LIMIT = 3000;
    // settling time after the last result
    localparam int TAIL_CYCLES    = 120;
    // random blocks after the directed table, one of them full length
    localparam int RAND_BLOCKS    = 36;
    localparam longint unsigned ENERGY_CAP = (64'd1 << LOG_W) - 1;

    // one row of the directed table, want only filled where it is obvious
    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        bit                 typed;
        t_out               want;
    } stim_row;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic out_valid;
    logic in_ready;
    t_out out_data;

    // shadow of the accumulator and the sample counter
    longint unsigned energy_acc = 0;
    int unsigned     tally      = 0;

    t_out pending_levels[$];
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    bit   steady       = 1'b0;
    int   hold_ticket  = 0;
    int   hold_taken   = 0;
    int   hold_left    = 0;

    // directed part: silence, full scale both ways, lowest codes, bit patterns
    stim_row dir_rows [18] = '{
        '{16'sd0,      1'b1, 1'b1, '{LEVEL_MIN, 1'b1, 11'd1}},
        '{16'sh8000,   1'b1, 1'b0, '0},
        '{16'sh7FFF,   1'b1, 1'b0, '0},
        '{16'sd1,      1'b1, 1'b0, '0},
        '{-16'sd1,     1'b1, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b0, '0},
        '{16'sd0,      1'b1, 1'b1, '{LEVEL_MIN, 1'b1, 11'd3}},
        '{16'sh5555,   1'b0, 1'b0, '0},
        '{16'shAAAA,   1'b1, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b0, '0},
        '{16'sd1,      1'b1, 1'b0, '0},
        '{16'sh7FFF,   1'b0, 1'b0, '0},
        '{16'sh8000,   1'b0, 1'b0, '0},
        '{16'sd0,      1'b0, 1'b0, '0},
        '{16'sd12345,  1'b1, 1'b0, '0},
        '{16'sd256,    1'b1, 1'b0, '0},
        '{-16'sd256,   1'b1, 1'b0, '0}
    };

    rms_level_meter_db_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 i_clk = ~i_clk;

    // log2 in q.16: msb index, then 16 fraction bits by repeated squaring
    // of the mantissa normalised to q1.31, truncating at every step
    function automatic logic [LOG_QW-1:0] log2_fix(input longint unsigned x);
        int              msb;
        longint unsigned m;
        logic [15:0]     frac;
        msb = 0;
        for (int b = 0; b < LOG_W; b++) begin
            if (x[b]) msb = b;
        end
        if (msb >= 31) m = x >> (msb - 31);
        else m = x << (31 - msb);
        frac = '0;
        for (int k = 0; k < FRAC_BITS; k++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd2 << 31)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {msb[EXP_W-1:0], frac};
    endfunction

    // level relative to full scale in 1/256 dB, halves rounded upwards
    function automatic logic signed [15:0] dbfs_of(input longint unsigned energy,
                                                   input int unsigned n);
        longint d;
        longint lvl;
        d = longint'(log2_fix(energy)) - longint'(log2_fix(longint'(n)))
            - longint'(LOG2_FS2);
        lvl = (d * longint'(DB_K) + (longint'(1) << 23)) >>> 24;
        if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
        if (lvl < LEVEL_MIN) lvl = LEVEL_MIN;
        return 16'(lvl);
    endfunction

    // adds one sample to the shadow block, returns 1 when the block closes
    function automatic bit absorb_sample(input t_in s, output t_out res);
        int              v;
        longint unsigned sq;
        v  = $signed(s.sample);
        sq = longint'(v) * longint'(v);
        if (ENERGY_CAP - energy_acc < sq) energy_acc = ENERGY_CAP;
        else energy_acc = energy_acc + sq;
        tally++;
        res = '0;
        if (!s.last && tally < MAX_BLOCK_DEF) return 1'b0;
        res.silent      = (energy_acc == 0);
        res.level_db    = res.silent ? LEVEL_MIN : dbfs_of(energy_acc, tally);
        res.block_count = CNT_OUT_W'(tally);
        energy_acc = 0;
        tally      = 0;
        return 1'b1;
    endfunction

    // block flavours: silence, near silence, extremes, anything
    function automatic logic signed [15:0] pick_sample(input int style);
        int v;
        v = int'($urandom_range(16)) - 8;
        case (style)
            0: return 16'sd0;
            1: return 16'(v);
            2: return $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            default: begin
                case ($urandom_range(11))
                    0: return 16'sd0;
                    1: return 16'sh8000;
                    2: return 16'sh7FFF;
                    3: return 16'(v);
                    default: return 16'($urandom);
                endcase
            end
        endcase
    endfunction

    // offer one sample request, with random gaps in front of it unless steady
    task automatic offer_sample(input t_in req, input bit typed, input t_out want);
        t_out res;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!in_ready);
        if (absorb_sample(req, res)) pending_levels.push_back(typed ? want : res);
    endtask

    // stop offering until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_levels.size() != 0);
    endtask

    // receiver: random ready, a steady stretch, and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ticket != hold_taken) begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_ticket;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result checker against the oldest outstanding expectation
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_levels.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result: level %0d silent %0b count %0d",
                             out_data.level_db, out_data.silent, out_data.block_count);
                end
                mismatches++;
            end else begin
                want = pending_levels.pop_front();
                if (out_data.level_db !== want.level_db || out_data.silent !== want.silent
                        || out_data.block_count !== want.block_count) begin
                    if (mismatches < 10) begin
                        $display("result mismatch: expected level %0d silent %0b count %0d,",
                                 want.level_db, want.silent, want.block_count,
                                 " got level %0d silent %0b count %0d",
                                 out_data.level_db, out_data.silent, out_data.block_count);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int  len;
        int  style;
        t_in req;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r]) begin
            req.sample = dir_rows[r].sample;
            req.last   = dir_rows[r].last;
            offer_sample(req, dir_rows[r].typed, dir_rows[r].want);
        end
        drain_results();

        // random blocks; one full-length block, closed by the count alone
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            if (blk == 5) steady <= 1'b1;
            if (blk == 14) steady <= 1'b0;
            // long receiver hold-off while blocks keep coming, input must stall
            if (blk == 18) hold_ticket <= hold_ticket + 1;
            if (blk == 26) drain_results();
            style = $urandom_range(9);
            if (blk == 8) len = MAX_BLOCK_DEF;
            else if ($urandom_range(7) == 0) len = 1;
            else len = $urandom_range(10, 2);
            for (int k = 1; k <= len; k++) begin
                req.sample = pick_sample(style);
                // block 8 never flags its end and has to be closed by the count
                req.last   = (k == len) && (blk != 8);
                offer_sample(req, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
